FILE: sv/bqe_pkg.sv
// Shared types, constants and rounding helper for the biquad equalizer.
`default_nettype none

package bqe_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int COEF_BITS     = 32;
    localparam int COEF_FRAC     = COEF_BITS - 4;
    localparam int GAIN_BITS     = 31;
    localparam int GAIN_FRAC     = 28;
    localparam int NUM_SECTIONS  = 5;
    localparam int COEF_IDX_BITS = 5;

    // taps per section: b0 b1 b2 a1 a2; history: x1 x2 y1 y2
    localparam int TAPS          = 5;
    localparam int STEP_BITS     = $clog2(TAPS);
    localparam int HIST_TAPS     = 4;
    localparam int HIST_IDX_BITS = $clog2(HIST_TAPS);
    localparam int TAP_A1        = 3;
    localparam int HIST_X1       = 0;
    localparam int HIST_X2       = 1;
    localparam int HIST_Y1       = 2;
    localparam int HIST_Y2       = 3;

    localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;
    localparam int GPROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int ACC_BITS   = PROD_BITS + 3;

    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC;
    localparam logic [GAIN_BITS-1:0]        GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC;

    localparam logic signed [ACC_BITS-1:0] SAT_MAX = ACC_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_MIN = -SAT_MAX - ACC_BITS'(1);

    typedef enum logic {
        OP_FILTER = 1'b0,
        OP_COEF   = 1'b1
    } opcode_t;

    typedef struct packed {
        logic                          opcode;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [COEF_IDX_BITS-1:0]      coef_index;
        logic signed [COEF_BITS-1:0]   coef_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          clipped;
    } out_item_t;

    typedef struct packed {
        logic                        en;
        logic [COEF_IDX_BITS-1:0]    idx;
        logic signed [COEF_BITS-1:0] value;
    } coef_wr_t;

    typedef struct packed {
        logic                          valid;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          clip;
    } sample_tok_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          clip;
    } rs_t;

    // round half up by sh bits, then saturate to the sample range
    function automatic rs_t round_sat(input logic signed [ACC_BITS-1:0] v,
                                      input int unsigned sh);
        logic signed [ACC_BITS-1:0] half;
        logic signed [ACC_BITS-1:0] r;
        rs_t res;
        half = ACC_BITS'(1) << (sh - 1);
        r    = (v + half) >>> sh;
        if (r > SAT_MAX) begin
            res.value = SAT_MAX[SAMPLE_BITS-1:0];
            res.clip  = 1'b1;
        end else if (r < SAT_MIN) begin
            res.value = SAT_MIN[SAMPLE_BITS-1:0];
            res.clip  = 1'b1;
        end else begin
            res.value = r[SAMPLE_BITS-1:0];
            res.clip  = 1'b0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: sv/bqe_cell.sv
// One biquad section: coefficients, history and a serial multiply-accumulate.
`default_nettype none

module bqe_cell
    import bqe_pkg::*;
#(
    parameter int SECT_ID = 0
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  coef_wr_t    coef_wr,
    input  sample_tok_t tok_in,
    output sample_tok_t tok_out
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_MUL,
        C_DRAIN,
        C_FINISH
    } cstate_t;

    cstate_t                       state_reg;
    logic [STEP_BITS-1:0]          step_reg;
    logic                          pv_reg;
    logic                          neg_reg;
    logic signed [COEF_BITS-1:0]   coef_reg [TAPS];
    logic signed [SAMPLE_BITS-1:0] hist_reg [HIST_TAPS];
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          clip_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_clip_reg;

    logic [HIST_IDX_BITS-1:0]      hidx;
    logic signed [SAMPLE_BITS-1:0] op_sel;
    logic signed [PROD_BITS-1:0]   prod_next;
    logic signed [ACC_BITS-1:0]    prod_ext;
    rs_t                           rs;

    // tap 0 multiplies the new sample, taps 1..4 the history words
    assign hidx      = HIST_IDX_BITS'(step_reg - STEP_BITS'(1));
    assign op_sel    = (step_reg == '0) ? x_reg : hist_reg[hidx];
    assign prod_next = coef_reg[step_reg] * op_sel;
    assign prod_ext  = ACC_BITS'(prod_reg);
    assign rs        = round_sat(acc_reg, COEF_FRAC);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= C_IDLE;
            step_reg      <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < TAPS; k++) begin
                coef_reg[k] <= (k == 0) ? COEF_ONE : '0;
            end
            for (int h = 0; h < HIST_TAPS; h++) begin
                hist_reg[h] <= '0;
            end
        end else begin
            out_valid_reg <= 1'b0;
            pv_reg        <= 1'b0;
            case (state_reg)
                C_IDLE: begin
                    if (tok_in.valid) begin
                        step_reg  <= '0;
                        state_reg <= C_MUL;
                    end
                end
                C_MUL: begin
                    pv_reg <= 1'b1;
                    if (step_reg == STEP_BITS'(TAPS - 1)) begin
                        state_reg <= C_DRAIN;
                    end else begin
                        step_reg <= step_reg + STEP_BITS'(1);
                    end
                end
                C_DRAIN: begin
                    state_reg <= C_FINISH;
                end
                C_FINISH: begin
                    out_valid_reg     <= 1'b1;
                    hist_reg[HIST_X2] <= hist_reg[HIST_X1];
                    hist_reg[HIST_X1] <= x_reg;
                    hist_reg[HIST_Y2] <= hist_reg[HIST_Y1];
                    hist_reg[HIST_Y1] <= rs.value;
                    state_reg         <= C_IDLE;
                end
                default: begin
                    state_reg <= C_IDLE;
                end
            endcase
            for (int k = 0; k < TAPS; k++) begin
                if (coef_wr.en && (int'(coef_wr.idx) == SECT_ID * TAPS + k)) begin
                    coef_reg[k] <= coef_wr.value;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == C_IDLE && tok_in.valid) begin
            x_reg    <= tok_in.sample;
            clip_reg <= tok_in.clip;
            acc_reg  <= '0;
        end else if (pv_reg) begin
            acc_reg <= neg_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
        end
        if (state_reg == C_MUL) begin
            prod_reg <= prod_next;
            neg_reg  <= (step_reg >= STEP_BITS'(TAP_A1));
        end
        if (state_reg == C_FINISH) begin
            out_sample_reg <= rs.value;
            out_clip_reg   <= clip_reg | rs.clip;
        end
    end

    assign tok_out.valid  = out_valid_reg;
    assign tok_out.sample = out_sample_reg;
    assign tok_out.clip   = out_clip_reg;

endmodule

`default_nettype wire

FILE: sv/bqe_gain.sv
// Output gain stage: multiply, round, saturate, hold result until taken.
`default_nettype none

module bqe_gain
    import bqe_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    input  sample_tok_t          tok_in,
    input  wire [GAIN_BITS-1:0]  gain,
    input  wire                  take,
    output wire                  res_valid,
    output out_item_t            res
);

    logic                         mul_valid_reg;
    logic                         res_valid_reg;
    logic signed [GPROD_BITS-1:0] prod_reg;
    logic                         clip_reg;
    out_item_t                    res_reg;
    rs_t                          rs;

    assign rs = round_sat(ACC_BITS'(prod_reg), GAIN_FRAC);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            mul_valid_reg <= tok_in.valid;
            if (mul_valid_reg) begin
                res_valid_reg <= 1'b1;
            end else if (take) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_in.valid) begin
            prod_reg <= tok_in.sample * $signed({1'b0, gain});
            clip_reg <= tok_in.clip;
        end
        if (mul_valid_reg) begin
            res_reg.sample_out <= rs.value;
            res_reg.clipped    <= clip_reg | rs.clip;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

FILE: sv/five_section_biquad_equalizer.sv
// Top level of the cascaded biquad equalizer: cell chain, gain stage, output register.
`default_nettype none

// Five-section biquad equalizer. Each input item either filters one Q1.23
// sample or writes one Q4.28 coefficient word (index section*5 + k, k being
// b0 b1 b2 a1 a2; indexes past the last section are dropped). A sample runs
// through a chain of identical section cells, each with its own coefficients,
// history and a 32x24 multiplier stepped over its five taps, then through the
// output gain multiplier. In each cell the five serial taps are followed by
// drain and round/saturate steps. One item is in flight at a time, and a
// coefficient item gives no result. A finished result waits in the output
// register while the next item is taken. output_gain (unsigned Q3.28) is
// written on the cfg port; the user must write it only while the block is
// idle, as the block itself does not enforce this. Reset clears the history
// and sets every section to pass-through.
module five_section_biquad_equalizer
    import bqe_pkg::*;
#(
    parameter int SECTIONS = NUM_SECTIONS
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output wire                 s_ready,
    input  in_item_t            s_data,
    output wire                 m_valid,
    input  wire                 m_ready,
    output out_item_t           m_data,
    input  wire                 cfg_valid,
    output wire                 cfg_ready,
    input  wire [GAIN_BITS-1:0] cfg_data
);

    logic                 busy_reg;
    logic                 m_valid_reg;
    out_item_t            m_data_reg;
    logic [GAIN_BITS-1:0] output_gain_reg;

    logic                 accept;
    logic                 load;
    logic                 gres_valid;
    out_item_t            gres;
    coef_wr_t             coef_wr;
    sample_tok_t          tok [SECTIONS+1];
    logic [SECTIONS:0]    tok_valid;

    assign s_ready   = !busy_reg;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    // sample items enter the chain; coefficient items go straight to the cells
    assign tok[0].valid  = accept && (s_data.opcode == OP_FILTER);
    assign tok[0].sample = s_data.sample_in;
    assign tok[0].clip   = 1'b0;

    assign coef_wr.en    = accept && (s_data.opcode == OP_COEF);
    assign coef_wr.idx   = s_data.coef_index;
    assign coef_wr.value = s_data.coef_value;

    genvar g;
    generate
        for (g = 0; g < SECTIONS; g++) begin : g_cell
            bqe_cell #(
                .SECT_ID (g)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .coef_wr (coef_wr),
                .tok_in  (tok[g]),
                .tok_out (tok[g+1])
            );
        end
        for (g = 0; g <= SECTIONS; g++) begin : g_tv
            assign tok_valid[g] = tok[g].valid;
        end
    endgenerate

    bqe_gain u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_in    (tok[SECTIONS]),
        .gain      (output_gain_reg),
        .take      (load),
        .res_valid (gres_valid),
        .res       (gres)
    );

    // the gain result moves into the output register once it is free
    assign load = gres_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
            output_gain_reg <= GAIN_ONE;
        end else begin
            if (tok[0].valid) begin
                busy_reg <= 1'b1;
            end else if (load) begin
                busy_reg <= 1'b0;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                output_gain_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= gres;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    // only one sample in flight anywhere along the chain
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({gres_valid, tok_valid}))
        else $error("more than one sample in flight");

    // any sample past the input keeps the block busy
    a_busy_cover: assert property (@(posedge aclk) disable iff (!aresetn)
        ((|tok_valid[SECTIONS:1]) || gres_valid) |-> busy_reg)
        else $error("sample in chain while block idle");

    // gain result appears after the last cell hands over, via the multiply register and then the result register
    a_gain_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(gres_valid) |-> $past(tok_valid[SECTIONS], 2))
        else $error("gain result without matching cell output");
`endif

endmodule

`default_nettype wire
